FILE: rtl/wtvb_pkg.sv
`default_nettype none

package wtvb_pkg;

  // Default sizes of the vocabulary and of one word slot.
  localparam int unsigned VOCAB_DEPTH_DEF = 128;
  localparam int unsigned WORD_LEN_DEF    = 32;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TOKEN_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [TOKEN_W-1:0] token_t;

  localparam char_t SEP_CHAR = char_t'(32);

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND   = 2'd0,
    STAT_ADDED   = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  // Strobes from the input handshake to the word buffer.
  typedef struct packed {
    logic push;   // A word byte was accepted.
    logic clear;  // A separator was accepted.
  } wb_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/wtvb_if.sv
`default_nettype none

interface wtvb_text_if;
  logic                 valid;
  logic                 ready;
  wtvb_pkg::char_t      char_byte;
  logic                 end_of_text;

  modport source (output valid, char_byte, end_of_text, input ready);
  modport sink   (input valid, char_byte, end_of_text, output ready);
endinterface

interface wtvb_token_if;
  logic                 valid;
  logic                 ready;
  wtvb_pkg::token_t     token_id;
  logic [wtvb_pkg::STATUS_W-1:0] status;

  modport source (output valid, token_id, status, input ready);
  modport sink   (input valid, token_id, status, output ready);
endinterface

interface wtvb_cfg_if;
  logic valid;
  logic ready;
  logic lookup_only;

  modport source (output valid, lookup_only, input ready);
  modport sink   (input valid, lookup_only, output ready);
endinterface

`default_nettype wire

FILE: rtl/wtvb_word_buf.sv
`default_nettype none

// Collects the bytes of the current word and presents them with the bytes
// at and above the word length forced to zero.
module wtvb_word_buf #(
  parameter int unsigned WORD_LEN = wtvb_pkg::WORD_LEN_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire wtvb_pkg::wb_ctrl_t                ctrl_i,
  input  wire wtvb_pkg::char_t                   char_i,
  output      logic [$clog2(WORD_LEN+1)-1:0]     len_o,
  output      logic [(WORD_LEN-1)*wtvb_pkg::CHAR_W-1:0] key_o
);

  localparam int unsigned LW    = $clog2(WORD_LEN + 1);
  localparam int unsigned SLOTS = WORD_LEN - 1;

  logic [LW-1:0]   wlen_q, wlen_d;
  wtvb_pkg::char_t chars_q [SLOTS];

  always_comb begin
    wlen_d = wlen_q;
    if (ctrl_i.clear) begin
      wlen_d = '0;
    end else if (ctrl_i.push && (wlen_q < LW'(WORD_LEN))) begin
      wlen_d = wlen_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
    end else begin
      wlen_q <= wlen_d;
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (ctrl_i.push && (wlen_q == LW'(k))) begin
        chars_q[k] <= char_i;
      end
    end

    assign key_o[k*wtvb_pkg::CHAR_W +: wtvb_pkg::CHAR_W] =
        (LW'(k) < wlen_q) ? chars_q[k] : '0;
  end

  assign len_o = wlen_q;

endmodule

`default_nettype wire

FILE: rtl/word_tokenizer_vocab_builder_top.sv
`default_nettype none

// Channel   Dir  Role    Payload
// text_i    in   sink    char_byte[7:0], end_of_text
// token_o   out  source  token_id[6:0], status[1:0]
// cfg_i     in   sink    lookup_only
//
// A word byte is accepted whenever the block is idle. A separator that closes
// a word of 1 to WORD_LEN-1 bytes starts a scan of the entry memory, one
// stored row per cycle through its single read port; with an empty vocabulary
// it goes straight to the decision. Reset clears the word length, the entry
// count and the mode; the memory needs no clearing pass. A stalled token_o
// holds the finished word in its output register while text bytes keep
// flowing; only the decision on the next such word waits for the register to
// drain, and text input stops until that decision is made.
module word_tokenizer_vocab_builder_top #(
  parameter int unsigned VOCAB_DEPTH = wtvb_pkg::VOCAB_DEPTH_DEF,
  parameter int unsigned WORD_LEN    = wtvb_pkg::WORD_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  wtvb_text_if.sink        text_i,
  wtvb_token_if.source     token_o,
  wtvb_cfg_if.sink         cfg_i
);

  // Widths derived from the vocabulary and word sizes.
  localparam int unsigned AW    = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(VOCAB_DEPTH + 1);
  localparam int unsigned LW    = $clog2(WORD_LEN + 1);
  localparam int unsigned BW    = $clog2(WORD_LEN);
  localparam int unsigned KEY_W = (WORD_LEN - 1) * wtvb_pkg::CHAR_W;
  localparam int unsigned ROW_W = BW + KEY_W;

  // ---------------------------------------------------------------------
  // Input side: every accepted byte either extends the word or ends it.
  // ---------------------------------------------------------------------
  wtvb_pkg::state_e state_q, state_d;

  logic               in_ready;
  logic               in_fire;
  logic               is_sep;
  logic               start;
  wtvb_pkg::wb_ctrl_t wb_ctrl;
  logic [LW-1:0]      word_len;
  logic [KEY_W-1:0]   word_key;

  assign text_i.ready = in_ready;
  assign in_fire      = text_i.valid && in_ready;
  assign is_sep       = text_i.end_of_text || (text_i.char_byte == wtvb_pkg::SEP_CHAR);

  assign wb_ctrl.push  = in_fire && !is_sep;
  assign wb_ctrl.clear = in_fire && is_sep;

  wtvb_word_buf #(
    .WORD_LEN (WORD_LEN)
  ) u_word_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (wb_ctrl),
    .char_i (text_i.char_byte),
    .len_o  (word_len),
    .key_o  (word_key)
  );

  // Empty and overlong words end silently; only a storable word is looked up.
  assign start = wb_ctrl.clear && (word_len != '0) && (word_len < LW'(WORD_LEN));

  // ---------------------------------------------------------------------
  // Configuration: the mode bit is always writable.
  // ---------------------------------------------------------------------
  logic lookup_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lookup_q <= 1'b0;
    end else if (cfg_i.valid) begin
      lookup_q <= cfg_i.lookup_only;
    end
  end

  // ---------------------------------------------------------------------
  // Entry memory: one row per vocabulary entry, holding the stored length
  // and the word bytes with unused positions zeroed, so that a row compares
  // against the captured key in one equality test.
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0] mem [VOCAB_DEPTH];
  logic [ROW_W-1:0] rdata_q;
  logic             mem_re;
  logic             mem_we;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [ROW_W-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Scan and decision state.
  // ---------------------------------------------------------------------
  logic [CW-1:0]    count_q, count_d;     // entries stored so far
  logic [CW-1:0]    rd_idx_q, rd_idx_d;   // next row to read
  logic             cmp_vld_q, cmp_vld_d; // rdata_q holds a row to compare
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d; // row index that rdata_q holds
  logic             found_q, found_d;
  logic [AW-1:0]    hit_idx_q, hit_idx_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [BW-1:0]    key_len_q, key_len_d;

  logic out_valid_q, out_valid_d;
  wtvb_pkg::token_t  tok_q, tok_d;
  wtvb_pkg::status_e stat_q, stat_d;

  logic row_match;
  logic row_last;
  logic slot_free;
  logic res_fire;

  assign row_match = (rdata_q[ROW_W-1 -: BW] == key_len_q) && (rdata_q[KEY_W-1:0] == key_q);
  assign row_last  = ((CW'(cmp_idx_q) + CW'(1)) == count_q);
  assign slot_free = !out_valid_q || token_o.ready;

  assign raddr = rd_idx_q[AW-1:0];
  assign waddr = count_q[AW-1:0];
  assign wdata = {key_len_q, key_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wtvb_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (count_q == '0) ? wtvb_pkg::ST_DECIDE : wtvb_pkg::ST_SCAN;
        end
      end
      wtvb_pkg::ST_SCAN: begin
        if (cmp_vld_q && (row_match || row_last)) begin
          state_d = wtvb_pkg::ST_DECIDE;
        end
      end
      wtvb_pkg::ST_DECIDE: begin
        if (slot_free) begin
          state_d = wtvb_pkg::ST_IDLE;
        end
      end
      default: state_d = wtvb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    mem_re   = 1'b0;
    res_fire = 1'b0;
    unique case (state_q)
      wtvb_pkg::ST_IDLE:   in_ready = 1'b1;
      wtvb_pkg::ST_SCAN:   mem_re   = (rd_idx_q < count_q);
      wtvb_pkg::ST_DECIDE: res_fire = slot_free;
      default: in_ready = 1'b0;
    endcase
  end

  // Scan bookkeeping and the result of a decision.
  always_comb begin
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    found_d   = found_q;
    hit_idx_d = hit_idx_q;
    key_d     = key_q;
    key_len_d = key_len_q;
    count_d   = count_q;
    mem_we    = 1'b0;
    tok_d     = tok_q;
    stat_d    = stat_q;

    if (start) begin
      key_d     = word_key;
      key_len_d = word_len[BW-1:0];
      rd_idx_d  = '0;
      found_d   = 1'b0;
    end

    if (mem_re) begin
      rd_idx_d  = rd_idx_q + CW'(1);
      cmp_vld_d = 1'b1;
      cmp_idx_d = rd_idx_q[AW-1:0];
    end

    // The first equal row in insertion order wins; the scan stops there.
    if ((state_q == wtvb_pkg::ST_SCAN) && cmp_vld_q && row_match) begin
      found_d   = 1'b1;
      hit_idx_d = cmp_idx_q;
    end

    if (res_fire) begin
      priority if (found_q) begin
        tok_d  = wtvb_pkg::token_t'(hit_idx_q);
        stat_d = wtvb_pkg::STAT_FOUND;
      end else if (lookup_q) begin
        tok_d  = '0;
        stat_d = wtvb_pkg::STAT_UNKNOWN;
      end else if (count_q >= CW'(VOCAB_DEPTH)) begin
        tok_d  = '0;
        stat_d = wtvb_pkg::STAT_FULL;
      end else begin
        tok_d   = wtvb_pkg::token_t'(count_q);
        stat_d  = wtvb_pkg::STAT_ADDED;
        mem_we  = 1'b1;
        count_d = count_q + CW'(1);
      end
    end
  end

  // The output register frees as its word is taken and refills on a decision.
  always_comb begin
    out_valid_d = out_valid_q;
    if (token_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wtvb_pkg::ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    key_q     <= key_d;
    key_len_q <= key_len_d;
    tok_q     <= tok_d;
    stat_q    <= stat_d;
  end

  assign token_o.valid    = out_valid_q;
  assign token_o.token_id = tok_q;
  assign token_o.status   = stat_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // The vocabulary never grows past its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(VOCAB_DEPTH))
    else $error("entry count exceeds vocabulary depth");

  // A row is written only into free space.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (count_q < CW'(VOCAB_DEPTH)))
    else $error("entry write with a full vocabulary");

  // Only rows that hold stored entries are ever compared.
  a_cmp_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (CW'(cmp_idx_q) < count_q))
    else $error("compare of a row beyond the entry count");

  // A hit always names a stored entry.
  a_hit_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && found_q) |-> (CW'(hit_idx_q) < count_q))
    else $error("hit index beyond the entry count");

  // A decision always lands in the output register.
  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |=> out_valid_q)
    else $error("decided word lost before the output register");

endmodule

`default_nettype wire

FILE: test/word_tokenizer_vocab_builder_token_check.sv
`timescale 1ns / 1ps

module word_tokenizer_vocab_builder_token_check #(
  parameter int unsigned VOCAB_DEPTH = wtvb_pkg::VOCAB_DEPTH_DEF,
  parameter int unsigned WORD_LEN    = wtvb_pkg::WORD_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wtvb_text_if        text_i,
  wtvb_token_if       token_i,
  wtvb_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  import wtvb_pkg::*;

  typedef struct packed {
    token_t  token_id;
    status_e status;
  } token_word_t;

  char_t       word_buf   [WORD_LEN];
  int unsigned word_cnt;
  char_t       entry_text [VOCAB_DEPTH][WORD_LEN];
  int unsigned entry_len  [VOCAB_DEPTH];
  int unsigned entry_total;
  bit          frozen;
  token_word_t expected_tokens [$];

  // Index of the first stored entry equal to the pending word, or -1.
  function automatic int find_entry(input int unsigned len);
    for (int e = 0; e < int'(entry_total); e++) begin
      if (entry_len[e] == len) begin
        bit same;
        same = 1'b1;
        for (int k = 0; k < int'(len); k++) begin
          if (entry_text[e][k] != word_buf[k]) same = 1'b0;
        end
        if (same) return e;
      end
    end
    return -1;
  endfunction

  // Advances the word state by one text word. Returns 1 when that word
  // closes a word of legal length, with the token it must produce.
  function automatic bit tokenize(input char_t c, input logic eot, output token_word_t tok);
    int unsigned len;
    int          hit;
    tok = '{token_id: '0, status: STAT_FOUND};
    if (!eot && c != SEP_CHAR) begin
      if (word_cnt < WORD_LEN - 1) word_buf[word_cnt] = c;
      if (word_cnt < WORD_LEN) word_cnt++;
      return 1'b0;
    end
    len      = word_cnt;
    word_cnt = 0;
    if (len == 0 || len >= WORD_LEN) return 1'b0;
    hit = find_entry(len);
    if (hit >= 0) begin
      tok = '{token_id: token_t'(hit), status: STAT_FOUND};
    end else if (frozen) begin
      tok = '{token_id: '0, status: STAT_UNKNOWN};
    end else if (entry_total >= VOCAB_DEPTH) begin
      tok = '{token_id: '0, status: STAT_FULL};
    end else begin
      for (int k = 0; k < int'(len); k++) entry_text[entry_total][k] = word_buf[k];
      entry_len[entry_total] = len;
      tok = '{token_id: token_t'(entry_total), status: STAT_ADDED};
      entry_total++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_word_t tok;
    if (!rst_ni) begin
      word_cnt     = 0;
      entry_total  = 0;
      frozen       = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      expected_tokens.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) frozen = cfg_i.lookup_only;
      if (text_i.valid && text_i.ready) begin
        if (tokenize(text_i.char_byte, text_i.end_of_text, tok)) expected_tokens.push_back(tok);
      end
      if (token_i.valid && token_i.ready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with no word pending: token_id %0d, status %0d",
                 token_i.token_id, token_i.status);
          fail_count_o++;
        end else begin
          tok = expected_tokens.pop_front();
          if (token_i.token_id !== tok.token_id) begin
            $error("token_id mismatch: expected %0d, actual %0d", tok.token_id, token_i.token_id);
            fail_count_o++;
          end
          if (token_i.status !== tok.status) begin
            $error("status mismatch: expected %0d, actual %0d", tok.status, token_i.status);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_tokens.size();
    end
  end

endmodule

FILE: test/word_tokenizer_vocab_builder_top_test.sv
`timescale 1ns / 1ps

module word_tokenizer_vocab_builder_top_test;

  import wtvb_pkg::*;

  localparam int unsigned VOCAB_DEPTH = VOCAB_DEPTH_DEF;
  localparam int unsigned WORD_LEN    = WORD_LEN_DEF;
  // Room for the longest word the stimulus builds: three bytes past the overlong limit.
  localparam int unsigned SPELL_MAX   = WORD_LEN + 4;
  // A full scan of the vocabulary plus a margin for the output register.
  localparam int unsigned SCAN_WAIT   = VOCAB_DEPTH + 8;
  // Long enough for the output register to fill and the text side to stall.
  localparam int unsigned HOLD_CYCLES = 3 * (VOCAB_DEPTH + 3);
  localparam int unsigned POOL_MAX    = 64;

  // A word as the stimulus spells it, before its separator.
  typedef struct packed {
    int unsigned                 len;
    logic [SPELL_MAX-1:0][7:0]   text;
  } spelled_t;

  logic clk;
  logic rst_n;

  wtvb_text_if  text_if ();
  wtvb_token_if token_if ();
  wtvb_cfg_if   cfg_if ();

  int unsigned fail_total;
  int unsigned expected_left;

  // Idle chances in percent for the text sender and the token receiver.
  int unsigned send_idle_pct;
  int unsigned take_idle_pct;
  // Raised by the stimulus to have the receiver hold off for HOLD_CYCLES.
  bit          hold_request;
  int unsigned items_sent;
  // Earlier words of legal length, reused to hit stored entries again.
  spelled_t    word_pool [$];

  word_tokenizer_vocab_builder_top #(
    .VOCAB_DEPTH (VOCAB_DEPTH),
    .WORD_LEN    (WORD_LEN)
  ) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .text_i  (text_if),
    .token_o (token_if),
    .cfg_i   (cfg_if)
  );

  word_tokenizer_vocab_builder_token_check #(
    .VOCAB_DEPTH (VOCAB_DEPTH),
    .WORD_LEN    (WORD_LEN)
  ) u_token_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .text_i       (text_if),
    .token_i      (token_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_total),
    .pending_o    (expected_left)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Any byte but the space, so that it always lands inside a word.
  function automatic char_t word_char();
    char_t c;
    do c = char_t'($urandom_range(255)); while (c == SEP_CHAR);
    return c;
  endfunction

  // Offers one text word and returns at the edge that accepts it. Valid stays
  // high afterwards so that back-to-back words need no second assignment in
  // one time step; a gap or settle_block() lowers it.
  task automatic offer_text(input char_t c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid       <= 1'b1;
    text_if.char_byte   <= c;
    text_if.end_of_text <= eot;
    do @(posedge clk); while (!text_if.ready);
    items_sent++;
  endtask

  // Sends the bytes of a word and closes it with a space or an end-of-text
  // mark. With the mark the byte is don't-care, so it may even be a space.
  task automatic send_spelled(input spelled_t w, input bit by_eot);
    for (int k = 0; k < int'(w.len); k++) offer_text(w.text[k], 1'b0);
    if (by_eot) begin
      offer_text(char_t'($urandom_range(255)), 1'b1);
    end else begin
      offer_text(SEP_CHAR, 1'b0);
    end
  endtask

  // Stops the text stream and waits until every token has come back. Words
  // that give no token may still be in flight, so a full scan time follows.
  task automatic settle_block();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SCAN_WAIT) @(posedge clk);
  endtask

  // Writes the mode register. Called only with the block idle.
  task automatic write_mode(input logic frozen);
    cfg_if.valid       <= 1'b1;
    cfg_if.lookup_only <= frozen;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // One random word. Most are short so that matches and the full vocabulary
  // are reached; some are near misses of a stored word (same length with one
  // byte changed, or one byte shorter), some sit at the longest legal length
  // and some are overlong and must be dropped. Now and then an extra space
  // ahead of the word makes an empty word.
  task automatic send_random_word();
    spelled_t    w;
    int unsigned pick;
    int unsigned lr;
    w    = '0;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 8) offer_text(SEP_CHAR, 1'b0);
    if (word_pool.size() != 0 && pick < 35) begin
      w = word_pool[$urandom_range(word_pool.size() - 1)];
    end else if (word_pool.size() != 0 && pick < 50) begin
      w = word_pool[$urandom_range(word_pool.size() - 1)];
      if (w.len > 1 && $urandom_range(1) == 1) begin
        w.len--;
      end else begin
        w.text[$urandom_range(w.len - 1)] = word_char();
      end
    end else begin
      lr = $urandom_range(99);
      if (lr < 65) begin
        w.len = $urandom_range(3, 1);
      end else if (lr < 85) begin
        w.len = $urandom_range(10, 4);
      end else if (lr < 93) begin
        w.len = $urandom_range(WORD_LEN - 1, WORD_LEN - 2);
      end else begin
        w.len = $urandom_range(WORD_LEN + 3, WORD_LEN);
      end
      for (int k = 0; k < int'(w.len); k++) w.text[k] = word_char();
      if (w.len < WORD_LEN && word_pool.size() < POOL_MAX) word_pool.push_back(w);
    end
    send_spelled(w, $urandom_range(99) < 20);
  endtask

  // Token receiver. A hold request turns into a long stretch with ready low,
  // counted here cycle by cycle, while the stimulus keeps offering text.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    token_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        token_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        token_if.ready <= 1'b0;
      end else begin
        token_if.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  initial begin
    spelled_t w;
    bit       stall_done;
    text_if.valid       <= 1'b0;
    text_if.char_byte   <= '0;
    text_if.end_of_text <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.lookup_only  <= 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 33;
    take_idle_pct = 75;
    hold_request  = 1'b0;
    items_sent    = 0;
    stall_done    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words in build mode. A leading space and a double space are
    // empty words; a word followed by a space and then an end mark checks that
    // the mark right after a separator gives nothing. The two-byte word uses
    // the lowest and highest byte values, and a later word shares its first
    // byte with the first entry to exercise a length mismatch.
    write_mode(1'b0);
    offer_text(SEP_CHAR, 1'b0);
    offer_text(8'h41, 1'b0);
    offer_text(SEP_CHAR, 1'b0);
    offer_text(SEP_CHAR, 1'b0);
    offer_text(8'h00, 1'b0);
    offer_text(8'hFF, 1'b0);
    offer_text(8'hDF, 1'b1);
    offer_text(8'h41, 1'b0);
    offer_text(SEP_CHAR, 1'b0);
    offer_text(8'h20, 1'b1);
    offer_text(8'h41, 1'b0);
    offer_text(8'h00, 1'b0);
    offer_text(SEP_CHAR, 1'b0);
    settle_block();

    // Frozen vocabulary: an unseen word is unknown, a stored one is found.
    write_mode(1'b1);
    offer_text(8'h5A, 1'b0);
    offer_text(SEP_CHAR, 1'b0);
    offer_text(8'h00, 1'b0);
    offer_text(8'hFF, 1'b0);
    offer_text(SEP_CHAR, 1'b0);
    settle_block();
    write_mode(1'b0);

    // Random words in build mode. Part way through, the receiver holds off
    // long enough that the block's output backs up and the text side stalls.
    while (items_sent < 150) begin
      if (!stall_done && items_sent >= 70) begin
        hold_request = 1'b1;
        stall_done   = 1'b1;
      end
      send_random_word();
    end
    settle_block();

    // Swap the idle rates. One-byte words of distinct values push the
    // vocabulary past its depth, so the tail of this run sees it full.
    send_idle_pct = 75;
    take_idle_pct = 33;
    for (int i = 0; i < 136; i++) begin
      if (char_t'(i) != SEP_CHAR) begin
        w         = '0;
        w.len     = 1;
        w.text[0] = char_t'(i);
        send_spelled(w, $urandom_range(99) < 25);
      end
    end
    while (items_sent < 470) send_random_word();
    settle_block();

    // Frozen and full, with no idling on either side.
    send_idle_pct = 0;
    take_idle_pct = 0;
    write_mode(1'b1);
    while (items_sent < 520) send_random_word();
    settle_block();

    if (fail_total == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
